>>> sv/nuss_pkg.sv
// ---------------------------------------------------------------------------
// nuss_pkg
// shared types, codes and defaults of the nested update set store
// ---------------------------------------------------------------------------
package nuss_pkg;

  localparam int unsigned ENTRIES_DEF       = 64;
  localparam int unsigned LEVELS_DEF        = 8;
  localparam int unsigned NESTING_DEF       = 32;
  localparam int unsigned LOCATION_BITS_DEF = 32;
  localparam int unsigned VALUE_BITS_DEF    = 32;
  localparam int unsigned MERGE_MIN         = 2;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_FORK   = 3'd2,
    OP_MERGE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CONFLICT = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOLEVEL  = 3'd3,
    ST_NEST     = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] location;
    logic [31:0] value;
    logic        kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] read_value;
    logic [31:0] existing_value;
    logic [3:0]  level_total;
    logic [5:0]  nest_total;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MSEL,
    S_MFIND,
    S_MAPPLY,
    S_DONE
  } state_t;

  // command broadcast from the sequencer along the cell row
  typedef enum logic [2:0] {
    CC_NONE,
    CC_WRITE,
    CC_SETVAL,
    CC_RELEVEL,
    CC_INVAL,
    CC_CLEAR
  } cell_cmd_t;

endpackage

>>> sv/nuss_cell.sv
// ---------------------------------------------------------------------------
// nuss_cell
// one entry slot; compares its tag and joins the priority chain to its neighbor
// ---------------------------------------------------------------------------
module nuss_cell #(
  parameter int unsigned LW = 3,
  parameter int unsigned AW = 32,
  parameter int unsigned VW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nuss_pkg::cell_cmd_t  cmd,
  input  logic                 sel,
  input  logic [LW-1:0]        cmp_level,
  input  logic [AW-1:0]        cmp_loc,
  input  logic [LW-1:0]        wr_level,
  input  logic [AW-1:0]        wr_loc,
  input  logic [VW-1:0]        wr_val,
  input  logic                 mfind_in,
  input  logic                 free_in,
  output logic                 mfind_out,
  output logic                 free_out,
  output logic                 match,
  output logic                 first_free,
  output logic                 lvl_hit,
  output logic [AW-1:0]        loc,
  output logic [VW-1:0]        val
);

  logic          valid;
  logic [LW-1:0] level;

  assign match      = valid && level == cmp_level && loc == cmp_loc;
  assign lvl_hit    = valid && level == cmp_level;
  // chain: first free slot, and any entry of the compared level at or below this cell
  assign first_free = !valid && !free_in;
  assign free_out   = free_in || !valid;
  assign mfind_out  = mfind_in || lvl_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd == nuss_pkg::CC_CLEAR) begin
      valid <= 1'b0;
    end else if (sel) begin
      case (cmd)
        nuss_pkg::CC_WRITE: valid <= 1'b1;
        nuss_pkg::CC_INVAL: valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (cmd)
        nuss_pkg::CC_WRITE: begin
          level <= wr_level;
          loc   <= wr_loc;
          val   <= wr_val;
        end
        nuss_pkg::CC_SETVAL:  val   <= wr_val;
        nuss_pkg::CC_RELEVEL: level <= wr_level;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/nuss_row.sv
// ---------------------------------------------------------------------------
// nuss_row
// row of entry cells with registered match and free results
// ---------------------------------------------------------------------------
module nuss_row #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned LW = 3,
  parameter int unsigned AW = 32,
  parameter int unsigned VW = 32,
  localparam int unsigned IW = $clog2(ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nuss_pkg::cell_cmd_t  cmd,
  input  logic [IW-1:0]        idx,
  input  logic [LW-1:0]        cmp_level,
  input  logic [AW-1:0]        cmp_loc,
  input  logic [LW-1:0]        wr_level,
  input  logic [AW-1:0]        wr_loc,
  input  logic [VW-1:0]        wr_val,
  output logic                 m_found,
  output logic [IW-1:0]        m_idx,
  output logic [VW-1:0]        m_val,
  output logic                 f_found,
  output logic [IW-1:0]        f_idx,
  output logic                 l_found,
  output logic [IW-1:0]        l_idx,
  output logic [AW-1:0]        l_loc,
  output logic [VW-1:0]        l_val
);

  logic [ENTRIES-1:0] match, ffree, lhit;
  logic [ENTRIES:0]   mchain, fchain;
  logic [AW-1:0]      locs [ENTRIES];
  logic [VW-1:0]      vals [ENTRIES];

  assign mchain[0] = 1'b0;
  assign fchain[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    nuss_cell #(.LW(LW), .AW(AW), .VW(VW)) u_cell (
      .clk, .rst, .cmd,
      .sel       (idx == IW'(g)),
      .cmp_level, .cmp_loc, .wr_level, .wr_loc, .wr_val,
      .mfind_in  (mchain[g]),
      .free_in   (fchain[g]),
      .mfind_out (mchain[g+1]),
      .free_out  (fchain[g+1]),
      .match     (match[g]),
      .first_free(ffree[g]),
      .lvl_hit   (lhit[g]),
      .loc       (locs[g]),
      .val       (vals[g])
    );
  end

  logic [IW-1:0] mi, fi, li;
  logic          lf;
  always_comb begin
    mi = '0;
    fi = '0;
    li = '0;
    lf = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) mi = IW'(i);
      if (ffree[i]) fi = IW'(i);
      if (lhit[i] && !lf) begin
        li = IW'(i);
        lf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_found <= |match;
    m_idx   <= mi;
    m_val   <= vals[mi];
    f_found <= fchain[ENTRIES];
    f_idx   <= fi;
    l_found <= mchain[ENTRIES];
    l_idx   <= li;
    l_loc   <= locs[li];
    l_val   <= vals[li];
  end

endmodule

>>> sv/nested_update_set_store.sv
// ---------------------------------------------------------------------------
// nested_update_set_store
// nested write-set store: a row of entry cells under a small sequencer
// ---------------------------------------------------------------------------
// channel   dir  payload                 handshake
// in        in   nuss_pkg::in_item_t     in_valid / in_stall
// out       out  nuss_pkg::out_item_t    out_valid / out_stall
//
// one item at a time; fork, clear, unknown ops and add with no level go straight to done,
// add searches the top level once, lookup searches level by level from the top down,
// merge finds, applies and may invalidate each entry of the top level in turn
// the row compare and its registered priority encoder set the step length
// rst clears the level and fork counts and all entry valid bits
// in_stall is high while an item is at work or its result is not taken
// ---------------------------------------------------------------------------
module nested_update_set_store #(
  parameter int unsigned ENTRIES       = nuss_pkg::ENTRIES_DEF,
  parameter int unsigned LEVELS        = nuss_pkg::LEVELS_DEF,
  parameter int unsigned NESTING       = nuss_pkg::NESTING_DEF,
  parameter int unsigned LOCATION_BITS = nuss_pkg::LOCATION_BITS_DEF,
  parameter int unsigned VALUE_BITS    = nuss_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  nuss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nuss_pkg::out_item_t out_data
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned NW = $clog2(NESTING);
  localparam int unsigned LCW = $clog2(LEVELS + 1);
  localparam int unsigned NCW = $clog2(NESTING + 1);

  nuss_pkg::state_t state, state_next;

  // item registers
  logic [2:0]               op;
  logic [LOCATION_BITS-1:0] loc;
  logic [VALUE_BITS-1:0]    val;

  // level and fork stacks
  logic [LEVELS-1:0]  level_kind;
  logic [NESTING-1:0] fork_flag;
  logic [LCW-1:0]     level_count;
  logic [NCW-1:0]     fork_count;

  // search / merge bookkeeping
  logic [LW-1:0]            scan_lvl;
  logic                     scan_phase;
  logic [2:0]               status;
  logic                     hit;
  logic [VALUE_BITS-1:0]    rd, existing;
  logic [IW-1:0]            src_idx;
  logic [LOCATION_BITS-1:0] src_loc;
  logic [VALUE_BITS-1:0]    src_val;

  // row port
  nuss_pkg::cell_cmd_t      cmd;
  logic [IW-1:0]            idx;
  logic [LW-1:0]            cmp_level, wr_level;
  logic [LOCATION_BITS-1:0] cmp_loc, wr_loc;
  logic [VALUE_BITS-1:0]    wr_val;
  logic                     m_found, f_found, l_found;
  logic [IW-1:0]            m_idx, f_idx, l_idx;
  logic [VALUE_BITS-1:0]    m_val, l_val;
  logic [LOCATION_BITS-1:0] l_loc;

  nuss_row #(.ENTRIES(ENTRIES), .LW(LW), .AW(LOCATION_BITS), .VW(VALUE_BITS)) u_row (
    .clk, .rst, .cmd, .idx, .cmp_level, .cmp_loc, .wr_level, .wr_loc, .wr_val,
    .m_found, .m_idx, .m_val, .f_found, .f_idx, .l_found, .l_idx, .l_loc, .l_val
  );

  logic          accept;
  logic [LW-1:0] top, par;
  assign accept   = in_valid && !in_stall;
  assign in_stall = state != nuss_pkg::S_IDLE;
  assign top      = LW'(level_count - LCW'(1));
  assign par      = LW'(level_count - LCW'(2));

  // merge is effective only with two fork records, a pushed level and two levels
  logic merge_go;
  assign merge_go = fork_count >= NCW'(nuss_pkg::MERGE_MIN)
                 && fork_flag[NW'(fork_count - NCW'(1))]
                 && level_count >= LCW'(nuss_pkg::MERGE_MIN);

  // second half of a merge step retires the source entry when the parent had it
  logic inval_pend;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nuss_pkg::S_IDLE: if (accept) begin
        state_next = nuss_pkg::S_DONE;
        case (in_data.op)
          nuss_pkg::OP_ADD:    if (level_count != '0) state_next = nuss_pkg::S_SCAN;
          nuss_pkg::OP_LOOKUP: if (level_count != '0) state_next = nuss_pkg::S_SCAN;
          nuss_pkg::OP_MERGE:  if (merge_go) state_next = nuss_pkg::S_MSEL;
          default: ;
        endcase
      end
      nuss_pkg::S_SCAN: if (scan_phase) begin
        if (op == nuss_pkg::OP_ADD) state_next = nuss_pkg::S_DONE;
        else if (m_found && !level_kind[scan_lvl]) state_next = nuss_pkg::S_DONE;
        else if (scan_lvl == '0) state_next = nuss_pkg::S_DONE;
      end
      // an invalidation holds the sequencer in select so the next search sees it
      nuss_pkg::S_MSEL:   if (!inval_pend) state_next = nuss_pkg::S_MFIND;
      nuss_pkg::S_MFIND:
        state_next = l_found ? nuss_pkg::S_MAPPLY : nuss_pkg::S_DONE;
      nuss_pkg::S_MAPPLY: if (scan_phase) state_next = nuss_pkg::S_MSEL;
      nuss_pkg::S_DONE:   if (!out_stall) state_next = nuss_pkg::S_IDLE;
      default: state_next = nuss_pkg::S_IDLE;
    endcase
  end

  // row commands
  always_comb begin
    cmd       = nuss_pkg::CC_NONE;
    idx       = '0;
    cmp_level = scan_lvl;
    cmp_loc   = loc;
    wr_level  = top;
    wr_loc    = loc;
    wr_val    = val;
    case (state)
      nuss_pkg::S_IDLE:
        if (accept && in_data.op == nuss_pkg::OP_CLEAR) cmd = nuss_pkg::CC_CLEAR;
      nuss_pkg::S_SCAN:
        if (scan_phase && op == nuss_pkg::OP_ADD) begin
          if (m_found) begin
            idx = m_idx;
            if (!level_kind[top]) cmd = nuss_pkg::CC_SETVAL;
          end else if (f_found) begin
            idx = f_idx;
            cmd = nuss_pkg::CC_WRITE;
          end
        end
      nuss_pkg::S_MSEL: begin
        cmp_level = top;
        if (inval_pend) begin
          idx = src_idx;
          cmd = nuss_pkg::CC_INVAL;
        end
      end
      nuss_pkg::S_MFIND: cmp_level = top;
      nuss_pkg::S_MAPPLY: begin
        cmp_level = par;
        cmp_loc   = src_loc;
        wr_level  = par;
        wr_val    = src_val;
        if (scan_phase) begin
          if (!m_found) begin
            idx = src_idx;
            cmd = nuss_pkg::CC_RELEVEL;
          end else if (!level_kind[par]) begin
            idx = m_idx;
            cmd = nuss_pkg::CC_SETVAL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= nuss_pkg::S_IDLE;
      level_count <= '0;
      fork_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next == nuss_pkg::S_DONE && state != nuss_pkg::S_DONE) out_valid <= 1'b1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        case (in_data.op)
          nuss_pkg::OP_FORK: begin
            logic push;
            push = level_count == '0 || level_kind[top] != in_data.kind;
            if (!(fork_count >= NCW'(NESTING) || (push && level_count >= LCW'(LEVELS))))
            begin
              if (push) level_count <= level_count + LCW'(1);
              fork_count <= fork_count + NCW'(1);
            end
          end
          nuss_pkg::OP_MERGE:
            if (fork_count >= NCW'(nuss_pkg::MERGE_MIN)) fork_count <= fork_count - NCW'(1);
          nuss_pkg::OP_CLEAR: begin
            level_count <= '0;
            fork_count  <= '0;
          end
          default: ;
        endcase
      end
      if (state == nuss_pkg::S_MFIND && !l_found) level_count <= level_count - LCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    inval_pend <= 1'b0;
    if (accept) begin
      op         <= in_data.op;
      loc        <= LOCATION_BITS'(in_data.location);
      val        <= VALUE_BITS'(in_data.value);
      status     <= nuss_pkg::ST_OK;
      hit        <= 1'b0;
      rd         <= '0;
      existing   <= '0;
      scan_lvl   <= top;
      scan_phase <= 1'b0;
      case (in_data.op)
        nuss_pkg::OP_ADD:
          if (level_count == '0) status <= nuss_pkg::ST_NOLEVEL;
        nuss_pkg::OP_FORK: begin
          logic push;
          push = level_count == '0 || level_kind[top] != in_data.kind;
          if (fork_count >= NCW'(NESTING) || (push && level_count >= LCW'(LEVELS)))
            status <= nuss_pkg::ST_NEST;
          else begin
            if (push) level_kind[LW'(level_count)] <= in_data.kind;
            fork_flag[NW'(fork_count)] <= push;
          end
        end
        default: ;
      endcase
    end
    case (state)
      nuss_pkg::S_SCAN: begin
        scan_phase <= !scan_phase;
        if (scan_phase) begin
          if (op == nuss_pkg::OP_ADD) begin
            if (m_found) begin
              if (level_kind[top] && m_val != val) begin
                status   <= nuss_pkg::ST_CONFLICT;
                existing <= m_val;
              end
            end else if (!f_found) status <= nuss_pkg::ST_FULL;
          end else if (m_found && !level_kind[scan_lvl]) begin
            hit <= 1'b1;
            rd  <= m_val;
          end else scan_lvl <= scan_lvl - LW'(1);
        end
      end
      nuss_pkg::S_MFIND: begin
        src_idx    <= l_idx;
        src_loc    <= l_loc;
        src_val    <= l_val;
        scan_phase <= 1'b0;
      end
      nuss_pkg::S_MAPPLY: begin
        scan_phase <= !scan_phase;
        if (scan_phase && m_found) begin
          inval_pend <= 1'b1;
          if (level_kind[par] && m_val != src_val && status == nuss_pkg::ST_OK) begin
            status   <= nuss_pkg::ST_CONFLICT;
            existing <= m_val;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data                = '0;
    out_data.status         = status;
    out_data.hit            = hit;
    out_data.read_value     = 32'(rd);
    out_data.existing_value = 32'(existing);
    out_data.level_total    = 4'(level_count);
    out_data.nest_total     = 6'(fork_count);
  end

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == nuss_pkg::S_DONE) else $error("result without done state");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_levels: assert property (@(posedge clk) disable iff (rst)
    level_count <= LCW'(LEVELS)) else $error("level stack overrun");
  a_forks: assert property (@(posedge clk) disable iff (rst)
    fork_count <= NCW'(NESTING)) else $error("fork stack overrun");

endmodule
